// ===== rtl/swrl_pkg.sv =====
// shared constants, types and helpers of the sliding window rate limiter
package swrl_pkg;

   // default sizes
   localparam int CLIENTS_DEFAULT     = 256;
   localparam int LOG_DEPTH_DEFAULT   = 32;
   localparam int TIME_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // fixed field widths
   localparam int CLIENT_FIELD_BITS = 8;
   localparam int STAMP_FIELD_BITS  = 32;
   localparam int LIMIT_BITS        = 6;
   localparam int WINDOW_BITS       = 32;
   localparam int RSP_COUNT_BITS    = 6;
   localparam int CSR_INDEX_BITS    = 8;
   localparam int CSR_DATA_BITS     = 32;
   localparam int REQ_DATA_BITS     = 40;
   localparam int RSP_DATA_BITS     = 8;
   // counts and limits are compared at this width (holds up to 127)
   localparam int CMP_BITS          = 7;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTEMPT_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 8'd1;

   // register reset values
   localparam logic [LIMIT_BITS-1:0]  ATTEMPT_LIMIT_RESET = 6'd30;
   localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET = 32'd60;

   // status from the back end to the front end
   typedef struct packed {
      logic clearing;
   } back_status_type;

   // bits needed to index n entries, at least one
   function automatic int index_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ===== rtl/swrl_ram.sv =====
// generic single write port ram with registered read
module swrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       write_enable,
   input  logic [swrl_pkg::index_bits(DEPTH)-1:0]     write_addr,
   input  logic [WIDTH-1:0]                           write_data,
   input  logic                                       read_enable,
   input  logic [swrl_pkg::index_bits(DEPTH)-1:0]     read_addr,
   output logic [WIDTH-1:0]                           read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/swrl_front.sv =====
// front end: takes request words, checks the client range, hands them to the queue
module swrl_front #(
   parameter int CLIENTS   = swrl_pkg::CLIENTS_DEFAULT,
   parameter int TIME_BITS = swrl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [swrl_pkg::CLIENT_FIELD_BITS-1:0]    req_client,
   input  logic [swrl_pkg::STAMP_FIELD_BITS-1:0]     req_stamp,
   input  swrl_pkg::back_status_type                 back_status,
   output logic                                      push_valid,
   input  logic                                      push_ready,
   output logic [swrl_pkg::CLIENT_FIELD_BITS+TIME_BITS:0] push_data
);

   localparam logic [31:0] CLIENT_LIMIT = 32'(CLIENTS);

   logic                                     hold_valid_ff;
   logic                                     hold_valid_in;
   logic [swrl_pkg::CLIENT_FIELD_BITS+TIME_BITS:0] hold_data_ff;
   logic [swrl_pkg::CLIENT_FIELD_BITS+TIME_BITS:0] hold_data_in;
   logic [63:0]                              stamp_wide;
   logic                                     out_of_range;
   logic                                     take;

   assign req_tready   = !back_status.clearing && (!hold_valid_ff || push_ready);
   assign take         = req_tvalid && req_tready;
   assign stamp_wide   = 64'(req_stamp);
   assign out_of_range = 32'(req_client) >= CLIENT_LIMIT;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (hold_valid_ff && push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_valid_in = 1'b1;
         // layout: range flag, client, time
         hold_data_in  = {out_of_range, req_client, stamp_wide[TIME_BITS-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_data_ff <= hold_data_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_data  = hold_data_ff;

endmodule

// ===== rtl/swrl_queue.sv =====
// short fifo between front end and back end
module swrl_queue #(
   parameter int WIDTH = 41,
   parameter int DEPTH = swrl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS  = swrl_pkg::index_bits(DEPTH);
   localparam int FILL_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]  LAST_SLOT = PTR_BITS'(DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FULL      = FILL_BITS'(DEPTH);

   logic [WIDTH-1:0]     slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff;
   logic [PTR_BITS-1:0]  wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff;
   logic [PTR_BITS-1:0]  rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = fill_ff != FULL;
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/swrl_back.sv =====
// back end: per-client log trimming, limit decision and result register
module swrl_back #(
   parameter int CLIENTS   = swrl_pkg::CLIENTS_DEFAULT,
   parameter int LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEFAULT,
   parameter int TIME_BITS = swrl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [swrl_pkg::LIMIT_BITS-1:0]            attempt_limit,
   input  logic [swrl_pkg::WINDOW_BITS-1:0]           window_length,
   input  logic                                       pop_valid,
   output logic                                       pop_ready,
   input  logic [swrl_pkg::CLIENT_FIELD_BITS+TIME_BITS:0] pop_data,
   output swrl_pkg::back_status_type                  back_status,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic                                       rsp_accepted,
   output logic [swrl_pkg::RSP_COUNT_BITS-1:0]        rsp_count
);

   localparam int CLIENT_BITS = swrl_pkg::index_bits(CLIENTS);
   localparam int HEAD_BITS   = swrl_pkg::index_bits(LOG_DEPTH);
   localparam int COUNT_BITS  = $clog2(LOG_DEPTH + 1);
   localparam int META_BITS   = HEAD_BITS + COUNT_BITS;
   localparam int STAMP_DEPTH = CLIENTS * LOG_DEPTH;
   localparam int ADDR_BITS   = swrl_pkg::index_bits(STAMP_DEPTH);
   localparam int SUM_BITS    = ((TIME_BITS > swrl_pkg::WINDOW_BITS) ?
                                 TIME_BITS : swrl_pkg::WINDOW_BITS) + 1;
   localparam int CB          = swrl_pkg::CMP_BITS;
   localparam logic [CLIENT_BITS-1:0] LAST_CLIENT = CLIENT_BITS'(CLIENTS - 1);
   localparam logic [HEAD_BITS-1:0]   LAST_HEAD   = HEAD_BITS'(LOG_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0]  DEPTH_COUNT = COUNT_BITS'(LOG_DEPTH);
   localparam logic [CB-1:0]          DEPTH_CMP   = CB'(LOG_DEPTH);
   localparam logic [ADDR_BITS-1:0]   DEPTH_ADDR  = ADDR_BITS'(LOG_DEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_META,
      ST_STAMP,
      ST_DECIDE
   } state_type;

   state_type                         state_ff, state_in;
   logic [CLIENT_BITS-1:0]            clear_idx_ff, clear_idx_in;
   logic [CLIENT_BITS-1:0]            client_ff, client_in;
   logic [TIME_BITS-1:0]              now_ff, now_in;
   logic [ADDR_BITS-1:0]              base_ff, base_in;
   logic [HEAD_BITS-1:0]              head_ff, head_in;
   logic [COUNT_BITS-1:0]             count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_accepted_ff, rsp_accepted_in;
   logic [swrl_pkg::RSP_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   // queue word fields
   logic                              q_out_of_range;
   logic [swrl_pkg::CLIENT_FIELD_BITS-1:0] q_client;
   logic [TIME_BITS-1:0]              q_now;

   // memory ports
   logic                              meta_we, meta_re;
   logic [CLIENT_BITS-1:0]            meta_waddr, meta_raddr;
   logic [META_BITS-1:0]              meta_wdata, meta_rdata;
   logic                              stamp_we, stamp_re;
   logic [ADDR_BITS-1:0]              stamp_waddr, stamp_raddr;
   logic [TIME_BITS-1:0]              stamp_rdata;

   // datapath helpers
   logic [HEAD_BITS-1:0]              rd_head;
   logic [COUNT_BITS-1:0]             rd_count;
   logic [ADDR_BITS-1:0]              base_calc;
   logic [SUM_BITS-1:0]               expiry;
   logic                              expired;
   logic [HEAD_BITS-1:0]              head_next;
   logic [COUNT_BITS-1:0]             count_dec;
   logic [COUNT_BITS:0]               tail_sum;
   logic [HEAD_BITS-1:0]              tail;
   logic [CB-1:0]                     limit_cmp;
   logic [COUNT_BITS-1:0]             count_inc;

   assign {q_out_of_range, q_client, q_now} = pop_data;

   assign rd_count  = (meta_rdata[COUNT_BITS-1:0] > DEPTH_COUNT) ?
                      DEPTH_COUNT : meta_rdata[COUNT_BITS-1:0];
   assign rd_head   = meta_rdata[META_BITS-1:COUNT_BITS];
   assign base_calc = ADDR_BITS'(client_ff) * DEPTH_ADDR;
   // stamp plus window, one bit wider so it cannot wrap
   assign expiry    = SUM_BITS'(stamp_rdata) + SUM_BITS'(window_length);
   assign expired   = expiry <= SUM_BITS'(now_ff);
   assign head_next = (head_ff == LAST_HEAD) ? '0 : head_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign count_inc = count_ff + 1'b1;
   // oldest plus live count, folded back into the ring
   assign tail_sum  = (COUNT_BITS + 1)'(head_ff) + (COUNT_BITS + 1)'(count_ff);
   assign tail      = (tail_sum >= (COUNT_BITS + 1)'(LOG_DEPTH)) ?
                      HEAD_BITS'(tail_sum - (COUNT_BITS + 1)'(LOG_DEPTH)) :
                      HEAD_BITS'(tail_sum);
   assign limit_cmp = (CB'(attempt_limit) > DEPTH_CMP) ? DEPTH_CMP : CB'(attempt_limit);

   always_comb begin
      state_in        = state_ff;
      clear_idx_in    = clear_idx_ff;
      client_in       = client_ff;
      now_in          = now_ff;
      base_in         = base_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_count_in    = rsp_count_ff;
      pop_ready       = 1'b0;
      meta_we         = 1'b0;
      meta_waddr      = client_ff;
      meta_wdata      = {head_ff, count_ff};
      meta_re         = 1'b0;
      meta_raddr      = CLIENT_BITS'(q_client);
      stamp_we        = 1'b0;
      stamp_waddr     = base_ff + ADDR_BITS'(tail);
      stamp_re        = 1'b0;
      stamp_raddr     = base_ff + ADDR_BITS'(head_next);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clear_idx_ff;
            meta_wdata = '0;
            if (clear_idx_ff == LAST_CLIENT) begin
               state_in = ST_IDLE;
            end else begin
               clear_idx_in = clear_idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop_valid && !rsp_valid_ff) begin
               pop_ready = 1'b1;
               client_in = CLIENT_BITS'(q_client);
               now_in    = q_now;
               if (q_out_of_range) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = 1'b0;
                  rsp_count_in    = '0;
               end else begin
                  meta_re  = 1'b1;
                  state_in = ST_META;
               end
            end
         end
         ST_META: begin
            head_in  = rd_head;
            count_in = rd_count;
            base_in  = base_calc;
            if (rd_count != '0) begin
               stamp_re    = 1'b1;
               stamp_raddr = base_calc + ADDR_BITS'(rd_head);
               state_in    = ST_STAMP;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_STAMP: begin
            if (expired) begin
               head_in  = head_next;
               count_in = count_dec;
               if (count_dec != '0) begin
                  stamp_re = 1'b1;
               end else begin
                  state_in = ST_DECIDE;
               end
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            meta_we      = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (CB'(count_ff) >= limit_cmp) begin
               rsp_accepted_in = 1'b0;
               rsp_count_in    = swrl_pkg::RSP_COUNT_BITS'(count_ff);
            end else begin
               stamp_we        = 1'b1;
               count_in        = count_inc;
               meta_wdata      = {head_ff, count_inc};
               rsp_accepted_in = 1'b1;
               rsp_count_in    = swrl_pkg::RSP_COUNT_BITS'(count_inc);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      client_ff       <= client_in;
      now_ff          <= now_in;
      base_ff         <= base_in;
      head_ff         <= head_in;
      count_ff        <= count_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_count_ff    <= rsp_count_in;
   end

   // per-client oldest index and live count
   swrl_ram #(
      .WIDTH (META_BITS),
      .DEPTH (CLIENTS)
   ) u_meta_ram (
      .clock        (clock),
      .write_enable (meta_we),
      .write_addr   (meta_waddr),
      .write_data   (meta_wdata),
      .read_enable  (meta_re),
      .read_addr    (meta_raddr),
      .read_data    (meta_rdata)
   );

   // timestamp rings, one row of LOG_DEPTH slots per client
   swrl_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (STAMP_DEPTH)
   ) u_stamp_ram (
      .clock        (clock),
      .write_enable (stamp_we),
      .write_addr   (stamp_waddr),
      .write_data   (now_ff),
      .read_enable  (stamp_re),
      .read_addr    (stamp_raddr),
      .read_data    (stamp_rdata)
   );

   assign back_status.clearing = state_ff == ST_CLEAR;
   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_accepted         = rsp_accepted_ff;
   assign rsp_count            = rsp_count_ff;

endmodule

// ===== rtl/sliding_window_rate_limiter.sv =====
// top level of the per-client sliding window log rate limiter
//
// channel   direction  handshake                  payload
// req_      in         req_tvalid / req_tready    tdata: client_index, timestamp_now
// rsp_      out        rsp_tvalid / rsp_tready    tdata: accepted, logged_count
// csr_      in         csr_valid / csr_ready      csr_index, csr_data
//
// a request passes ST_IDLE, ST_META, ST_STAMP for each logged stamp examined (each
// expired entry dropped, and the first live entry when the walk stops on it), ST_DECIDE
// and the result register; the trim walk reads one stamp per cycle from the single ring
// memory; an out-of-range client is answered from ST_IDLE and touches no log memory
// after reset a clearing pass writes zero to all CLIENTS head/count entries, one per
// cycle; req_tready stays low during the pass, csr writes are taken throughout
// the front end and a short queue keep taking request words, until they are full, while
// the back end trims or while a result waits in the output register
module sliding_window_rate_limiter #(
   parameter int CLIENTS   = swrl_pkg::CLIENTS_DEFAULT,
   parameter int LOG_DEPTH = swrl_pkg::LOG_DEPTH_DEFAULT,
   parameter int TIME_BITS = swrl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request words
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] client_index, [39:8] timestamp_now
   input  logic [swrl_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // result words
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] accepted, [6:1] logged_count, [7] zero
   output logic [swrl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swrl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [swrl_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int QUEUE_WIDTH = swrl_pkg::CLIENT_FIELD_BITS + TIME_BITS + 1;

   // configuration registers
   logic [swrl_pkg::LIMIT_BITS-1:0]  attempt_limit_ff, attempt_limit_in;
   logic [swrl_pkg::WINDOW_BITS-1:0] window_length_ff, window_length_in;

   // front end to queue
   logic                             push_valid;
   logic                             push_ready;
   logic [QUEUE_WIDTH-1:0]           push_data;
   // queue to back end
   logic                             pop_valid;
   logic                             pop_ready;
   logic [QUEUE_WIDTH-1:0]           pop_data;

   swrl_pkg::back_status_type        back_status;
   logic                             rsp_accepted;
   logic [swrl_pkg::RSP_COUNT_BITS-1:0] rsp_count;

   // register port never stalls; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      attempt_limit_in = attempt_limit_ff;
      window_length_in = window_length_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == swrl_pkg::REG_ATTEMPT_LIMIT) begin
            attempt_limit_in = csr_data[swrl_pkg::LIMIT_BITS-1:0];
         end else if (csr_index == swrl_pkg::REG_WINDOW_LENGTH) begin
            window_length_in = csr_data[swrl_pkg::WINDOW_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attempt_limit_ff <= swrl_pkg::ATTEMPT_LIMIT_RESET;
         window_length_ff <= swrl_pkg::WINDOW_LENGTH_RESET;
      end else begin
         attempt_limit_ff <= attempt_limit_in;
         window_length_ff <= window_length_in;
      end
   end

   // accept and classify
   swrl_front #(
      .CLIENTS   (CLIENTS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_client  (req_tdata[7:0]),
      .req_stamp   (req_tdata[39:8]),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // decoupling queue
   swrl_queue #(
      .WIDTH (QUEUE_WIDTH),
      .DEPTH (swrl_pkg::QUEUE_DEPTH_DEFAULT)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // trim, decide, log, answer
   swrl_back #(
      .CLIENTS   (CLIENTS),
      .LOG_DEPTH (LOG_DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .attempt_limit (attempt_limit_ff),
      .window_length (window_length_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .back_status   (back_status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_accepted  (rsp_accepted),
      .rsp_count     (rsp_count)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_accepted};

endmodule

// ===== verif/sliding_window_rate_limiter_test.sv =====
// self-checking testbench for the per-client sliding window rate limiter
module sliding_window_rate_limiter_test;

   import swrl_pkg::*;

   localparam int CLIENT_COUNT   = CLIENTS_DEFAULT;
   localparam int LOG_SLOTS      = LOG_DEPTH_DEFAULT;
   localparam int TARGET_REQS    = 1600;
   // requests at the end of the plan that run with no gaps or stalls
   localparam int QUIET_REQS     = 150;
   // pause after a drain before the next word goes out
   localparam int SETTLE_CYCLES  = 8;
   // worst request: ST_META, 32 trimmed stamps, ST_DECIDE and result register, with margin
   localparam int LATENCY_CYCLES = 64;
   localparam int DRAIN_GUARD    = 20000;

   typedef enum logic [1:0] {
      STEP_REQUEST,
      STEP_WRITE,
      STEP_DRAIN
   } plan_kind_type;

   typedef struct {
      plan_kind_type                kind;
      logic [CLIENT_FIELD_BITS-1:0] client;
      logic [STAMP_FIELD_BITS-1:0]  stamp;
      logic [CSR_INDEX_BITS-1:0]    index;
      logic [CSR_DATA_BITS-1:0]     data;
   } plan_item_type;

   typedef struct packed {
      logic                      accepted;
      logic [RSP_COUNT_BITS-1:0] logged_count;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // [7:0] client_index, [39:8] timestamp_now
   logic [REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [0] accepted, [6:1] logged_count, [7] zero fill
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   sliding_window_rate_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // shadow of the limiter: per-client stamp rings and the two registers
   // ------------------------------------------------------------------
   logic [STAMP_FIELD_BITS-1:0] stamp_log [CLIENT_COUNT][LOG_SLOTS];
   logic [4:0]                  log_head  [CLIENT_COUNT];
   int                          log_fill  [CLIENT_COUNT];
   logic [LIMIT_BITS-1:0]       limit_reg;
   logic [WINDOW_BITS-1:0]      window_reg;

   // trim the client's expired stamps, then admit and log or refuse
   function automatic verdict_type admit_request(input logic [CLIENT_FIELD_BITS-1:0] client,
                                                 input logic [STAMP_FIELD_BITS-1:0] now);
      logic [4:0]  head;
      int          fill;
      int          cap;
      verdict_type v;
      head = log_head[client];
      fill = log_fill[client];
      // expired when stamp + window <= now, summed one bit wider so it never wraps
      while (fill > 0 &&
             ({1'b0, stamp_log[client][head]} + {1'b0, window_reg} <= {1'b0, now})) begin
         head = head + 5'd1;
         fill--;
      end
      // a limit above the ring depth behaves as the ring depth
      cap = (limit_reg > LOG_SLOTS) ? LOG_SLOTS : int'(limit_reg);
      if (fill >= cap) begin
         v.accepted = 1'b0;
      end else begin
         stamp_log[client][head + fill[4:0]] = now;
         fill++;
         v.accepted = 1'b1;
      end
      log_head[client] = head;
      log_fill[client] = fill;
      v.logged_count = fill[RSP_COUNT_BITS-1:0];
      return v;
   endfunction

   // unused indexes are dropped by the block
   function automatic void apply_write(input logic [CSR_INDEX_BITS-1:0] index,
                                       input logic [CSR_DATA_BITS-1:0] data);
      if (index == REG_ATTEMPT_LIMIT) begin
         limit_reg = data[LIMIT_BITS-1:0];
      end else if (index == REG_WINDOW_LENGTH) begin
         window_reg = data[WINDOW_BITS-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // plan of words for the driver, built at time zero
   // ------------------------------------------------------------------
   plan_item_type request_plan [$];
   verdict_type   verdicts [$];
   int            reqs_left;
   int            planned_reqs;
   int            planned_pauses;
   logic [STAMP_FIELD_BITS-1:0] wall_time;

   task automatic plan_request(input logic [CLIENT_FIELD_BITS-1:0] client,
                               input logic [STAMP_FIELD_BITS-1:0] stamp);
      plan_item_type p;
      p = '{kind: STEP_REQUEST, client: client, stamp: stamp, index: '0, data: '0};
      request_plan = {request_plan, p};
      reqs_left++;
      planned_reqs++;
   endtask

   task automatic plan_write(input logic [CSR_INDEX_BITS-1:0] index,
                             input logic [CSR_DATA_BITS-1:0] data);
      plan_item_type p;
      p = '{kind: STEP_WRITE, client: '0, stamp: '0, index: index, data: data};
      request_plan = {request_plan, p};
   endtask

   // sender holds off until every outstanding result has come back
   task automatic plan_pause();
      plan_item_type p;
      p = '{kind: STEP_DRAIN, client: '0, stamp: '0, index: '0, data: '0};
      request_plan = {request_plan, p};
      planned_pauses++;
   endtask

   // move wall time forward, pinned at the top of the range
   task automatic advance_time(input logic [31:0] max_step);
      logic [32:0] sum;
      sum = {1'b0, wall_time} + 33'($urandom_range(0, max_step));
      wall_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endtask

   // ------------------------------------------------------------------
   // driver: request and register words, one at a time, with idle bursts
   // ------------------------------------------------------------------
   int   taken_count    = 0;
   int   answered_count = 0;
   int   admitted_total = 0;
   int   refused_total  = 0;
   int   write_total    = 0;
   int   gap_left;
   int   settle_left;
   int   gap_pct        = 20;
   logic quiet_tail     = 1'b0;
   logic req_hold;
   logic csr_hold;
   verdict_type fresh;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
         gap_left = 0;
         settle_left = 0;
         for (int c = 0; c < CLIENT_COUNT; c++) begin
            log_head[c] = '0;
            log_fill[c] = 0;
         end
         limit_reg  = ATTEMPT_LIMIT_RESET;
         window_reg = WINDOW_LENGTH_RESET;
      end else begin
         req_hold = req_tvalid && !req_tready;
         csr_hold = csr_valid && !csr_ready;
         if (req_tvalid && req_tready) begin
            fresh = admit_request(req_tdata[7:0], req_tdata[39:8]);
            verdicts = {verdicts, fresh};
            if (fresh.accepted) admitted_total++;
            else refused_total++;
            taken_count <= taken_count + 1;
            // change how bursty the sender is every hundred words
            if (taken_count % 100 == 0) begin
               case ($urandom_range(0, 2))
                  0: gap_pct = 0;
                  1: gap_pct = 10;
                  default: gap_pct = 35;
               endcase
            end
            if (!quiet_tail && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 4);
         end
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
            write_total++;
         end
         if (!req_hold && !csr_hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (settle_left > 0) begin
               settle_left--;
            end else if (request_plan.size() > 0) begin
               case (request_plan[0].kind)
                  STEP_REQUEST: begin
                     req_tdata <= {request_plan[0].stamp, request_plan[0].client};
                     req_hold = 1'b1;
                     request_plan.delete(0);
                     reqs_left--;
                  end
                  STEP_WRITE: begin
                     csr_index <= request_plan[0].index;
                     csr_data  <= request_plan[0].data;
                     csr_hold = 1'b1;
                     request_plan.delete(0);
                  end
                  STEP_DRAIN: begin
                     // counters are updated nonblocking, so both are last cycle's values;
                     // a request word taken at this edge is not counted yet
                     if (taken_count == answered_count && !(req_tvalid && req_tready)) begin
                        settle_left = SETTLE_CYCLES;
                        request_plan.delete(0);
                     end
                  end
                  default: ;
               endcase
            end
         end
         req_tvalid <= req_hold;
         csr_valid  <= csr_hold;
         quiet_tail <= (reqs_left < QUIET_REQS);
      end
   end

   // ------------------------------------------------------------------
   // monitor: result words against the oldest prediction, with stalls
   // ------------------------------------------------------------------
   int          failures = 0;
   int          stall_left;
   int          stall_pct = 20;
   verdict_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            answered_count <= answered_count + 1;
            if (verdicts.size() == 0) begin
               $error("result word %h with no request outstanding", rsp_tdata);
               failures++;
            end else begin
               want = verdicts[0];
               verdicts.delete(0);
               if (rsp_tdata[0] !== want.accepted) begin
                  $error("result %0d accepted: expected %0d, got %0d",
                         answered_count, want.accepted, rsp_tdata[0]);
                  failures++;
               end
               if (rsp_tdata[6:1] !== want.logged_count) begin
                  $error("result %0d logged_count: expected %0d, got %0d",
                         answered_count, want.logged_count, rsp_tdata[6:1]);
                  failures++;
               end
            end
            if (answered_count % 89 == 0) begin
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 15;
                  default: stall_pct = 45;
               endcase
            end
         end
         // stall bursts, none near the end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus plan, reset and end of run
   // ------------------------------------------------------------------
   int                     guard;
   int                     phase_len;
   int                     hot_count;
   logic [7:0]             hot_client [4];
   logic [LIMIT_BITS-1:0]  phase_limit;
   logic [31:0]            phase_window;
   logic [31:0]            max_step;
   logic [7:0]             pick_client;

   initial begin
      reqs_left = 0;
      planned_reqs = 0;
      planned_pauses = 0;

      // reset values: limit 30, window 60; an entry exactly one window old expires
      plan_request(8'd0, 32'd0);
      plan_request(8'd255, 32'd59);
      plan_request(8'd0, 32'd60);

      // limit 2 with junk in the upper data bits, window 10
      plan_pause();
      plan_write(REG_ATTEMPT_LIMIT, 32'hFFFF_FFC2);
      plan_write(REG_WINDOW_LENGTH, 32'd10);
      plan_request(8'd1, 32'd100);
      plan_request(8'd1, 32'd100);
      plan_request(8'd1, 32'd105);   // limit reached, refused
      plan_request(8'd1, 32'd110);   // both entries expire together
      plan_request(8'd1, 32'd109);   // time steps back

      // zero limit: everything refused, trimming still runs
      plan_pause();
      plan_write(REG_ATTEMPT_LIMIT, 32'd0);
      plan_request(8'd1, 32'd200);
      plan_request(8'd2, 32'd200);

      // limit above the ring depth, zero window
      plan_pause();
      plan_write(REG_ATTEMPT_LIMIT, 32'h0000_003F);
      plan_write(REG_WINDOW_LENGTH, 32'd0);
      plan_request(8'd4, 32'd300);
      plan_request(8'd4, 32'd300);   // same stamp already counts as expired
      plan_request(8'd4, 32'd299);

      // full-scale window, writes to unused indexes change nothing
      plan_pause();
      plan_write(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
      plan_write(8'hFF, 32'hFFFF_FFFF);
      plan_write(8'd2, 32'd0);
      plan_request(8'd5, 32'hFFFF_FFFE);
      plan_request(8'd5, 32'hFFFF_FFFF);
      plan_request(8'd255, 32'hFFFF_FFFF);
      plan_request(8'hAA, 32'hAAAA_AAAA);
      plan_request(8'h55, 32'h5555_5555);

      // random phases: a few busy clients per phase under a fresh setting
      wall_time = 32'h5555_5555;
      while (planned_reqs < TARGET_REQS) begin
         plan_pause();
         case ($urandom_range(0, 6))
            0: phase_limit = 6'd0;
            1: phase_limit = 6'd1;
            2: phase_limit = 6'd32;
            3: phase_limit = 6'($urandom_range(33, 63));
            4: phase_limit = 6'($urandom_range(1, 31));
            default: phase_limit = 6'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0: phase_window = 32'd0;
            1: phase_window = 32'hFFFF_FFFF;
            2: phase_window = $urandom;
            default: phase_window = $urandom_range(1, 64);
         endcase
         plan_write(REG_ATTEMPT_LIMIT, ($urandom & 32'hFFFF_FFC0) | 32'(phase_limit));
         plan_write(REG_WINDOW_LENGTH, phase_window);
         if ($urandom_range(0, 5) == 0) plan_write(8'($urandom_range(2, 255)), $urandom);

         case ($urandom_range(0, 4))
            0: wall_time = $urandom_range(0, 100);
            1: wall_time = 32'hFFFF_FF00 | $urandom_range(0, 255);
            2: wall_time = $urandom;
            default: ;   // carry on from the previous phase
         endcase
         if (phase_window <= 64) max_step = phase_window / 3 + 1;
         else max_step = phase_window >> $urandom_range(2, 6);

         hot_count = $urandom_range(1, 4);
         for (int h = 0; h < 4; h++) hot_client[h] = 8'($urandom_range(0, 255));
         phase_len = $urandom_range(40, 120);
         for (int n = 0; n < phase_len; n++) begin
            if ($urandom_range(0, 99) < 85) pick_client = hot_client[$urandom_range(0, hot_count - 1)];
            else pick_client = 8'($urandom_range(0, 255));
            // a few stamps step backward
            if ($urandom_range(0, 99) < 3) begin
               wall_time = (wall_time > 50) ? wall_time - $urandom_range(0, 50) : 32'd0;
            end else begin
               advance_time(max_step);
            end
            plan_request(pick_client, wall_time);
            if ($urandom_range(0, 99) < 2) plan_pause();
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (request_plan.size() != 0 || req_tvalid || csr_valid) @(posedge clock);
      guard = 0;
      while (answered_count != taken_count && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (verdicts.size() != 0) begin
         $error("%0d results never arrived", verdicts.size());
         failures++;
      end

      $display("covered %0d requests (%0d admitted, %0d refused) and %0d register writes",
               taken_count, admitted_total, refused_total, write_total);
      $display("limits from zero to 63, windows from zero to full scale, %0d drain pauses",
               planned_pauses);
      if (failures == 0) begin
         $display("sliding_window_rate_limiter_test passed");
      end else begin
         $display("sliding_window_rate_limiter_test failed");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #4000000;
      $display("sliding_window_rate_limiter_test failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/swrl_pkg.sv
rtl/swrl_ram.sv
rtl/swrl_front.sv
rtl/swrl_queue.sv
rtl/swrl_back.sv
rtl/sliding_window_rate_limiter.sv
verif/sliding_window_rate_limiter_test.sv
